### hdl/tlnsf_pkg.sv
// tlnsf_pkg: shared constants and types for the text line numbering and squeeze filter
// used by every module of the filter and by the channel interfaces
`default_nettype none

package tlnsf_pkg;

    localparam int BYTE_W        = 8;
    localparam int NUMBER_DIGITS = 6;
    localparam int MAX_RESULTS   = 8;

    // digit count clamped so digits, tab and byte fit in one run of results
    localparam int EFF_DIGITS = (NUMBER_DIGITS < 1) ? 1 :
                                (NUMBER_DIGITS > MAX_RESULTS - 2) ? MAX_RESULTS - 2 :
                                NUMBER_DIGITS;

    // emit position: digits, then tab, then the passed byte
    localparam int POS_W = $clog2(EFF_DIGITS + 2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE         = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'd48;

    localparam logic [3:0] BCD_NINE = 4'd9;

    typedef logic [EFF_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze;
    } cfg_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic              numbered;
        bcd_t              digits;
        logic [BYTE_W-1:0] text_byte;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/tlnsf_if.sv
// tlnsf_in_if and tlnsf_out_if: valid/ready channels of the filter
// depends on tlnsf_pkg for the byte width
`default_nettype none

interface tlnsf_in_if;
    logic                           valid;
    logic                           ready;
    logic [tlnsf_pkg::BYTE_W-1:0]   text_byte;
    logic                           file_start;

    modport source (output valid, output text_byte, output file_start, input ready);
    modport sink   (input valid, input text_byte, input file_start, output ready);
endinterface

interface tlnsf_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlnsf_pkg::BYTE_W-1:0]   out_byte;
    logic                           last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/tlnsf_front.sv
// tlnsf_front: accepts text bytes, tracks line state and the bcd line counter,
// classifies each byte and pushes a command unless it is squeezed; depends on tlnsf_pkg and tlnsf_if
`default_nettype none

module tlnsf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tlnsf_pkg::cfg_t        cfg,
    tlnsf_in_if.sink               text,
    input  wire logic              q_full,
    output logic                   q_push,
    output tlnsf_pkg::cmd_t        q_data
);
    import tlnsf_pkg::*;

    logic prev_nl_reg, prev_nl_next;
    logic blank_reg, blank_next;
    bcd_t count_reg, count_next;

    logic accept;
    logic is_nl;
    logic at_start;
    logic blank_eff;
    logic drop;
    logic numbered;
    logic all_nines;
    logic carry;
    bcd_t count_inc;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign is_nl      = (text.text_byte == CHAR_NEWLINE);
    assign at_start   = text.file_start || prev_nl_reg;
    assign blank_eff  = !text.file_start && blank_reg;
    assign drop       = at_start && is_nl && blank_eff && cfg.squeeze;

    always_comb
    begin
        numbered = 1'b0;
        if (at_start)
        begin
            if (cfg.number_nonblank)
                numbered = !is_nl;
            else
                numbered = cfg.number_all;
        end
    end

    // saturating bcd increment
    always_comb
    begin
        all_nines = 1'b1;
        carry     = 1'b1;
        count_inc = count_reg;
        for (int k = 0; k < EFF_DIGITS; k++)
        begin
            if (count_reg[k] != BCD_NINE)
                all_nines = 1'b0;
            if (carry)
            begin
                if (count_reg[k] == BCD_NINE)
                    count_inc[k] = 4'd0;
                else
                begin
                    count_inc[k] = count_reg[k] + 4'd1;
                    carry        = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        prev_nl_next = prev_nl_reg;
        blank_next   = blank_reg;
        count_next   = count_reg;
        if (accept && !drop)
        begin
            prev_nl_next = is_nl;
            blank_next   = at_start && is_nl;
            if (numbered && !all_nines)
                count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nl_reg <= 1'b1;
            blank_reg   <= 1'b0;
            count_reg   <= bcd_t'(1);
        end
        else
        begin
            prev_nl_reg <= prev_nl_next;
            blank_reg   <= blank_next;
            count_reg   <= count_next;
        end
    end

    assign q_push           = accept && !drop;
    assign q_data.numbered  = numbered;
    assign q_data.digits    = count_reg;
    assign q_data.text_byte = text.text_byte;

endmodule

`default_nettype wire

### hdl/tlnsf_queue.sv
// tlnsf_queue: short command fifo between front and back
// depends on tlnsf_pkg
`default_nettype none

module tlnsf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tlnsf_pkg::cmd_t    push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output tlnsf_pkg::cmd_t    head
);
    import tlnsf_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### hdl/tlnsf_back.sv
// tlnsf_back: expands numbered commands into padded digits, tab and byte, and sends other
// bytes alone, through a registered output stage; depends on tlnsf_pkg and tlnsf_if
`default_nettype none

module tlnsf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  tlnsf_pkg::cmd_t    q_head,
    output logic               q_pop,
    tlnsf_out_if.source        result
);
    import tlnsf_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              load;
    logic              final_pos;
    logic [BYTE_W-1:0] sel_byte;
    logic              seen_nonzero;
    logic [EFF_DIGITS-1:0] blank_digit;

    // leading zeros above the units digit show as spaces
    always_comb
    begin
        seen_nonzero = 1'b0;
        blank_digit  = '0;
        for (int k = EFF_DIGITS - 1; k >= 0; k--)
        begin
            if (q_head.digits[k] != 4'd0)
                seen_nonzero = 1'b1;
            blank_digit[k] = !seen_nonzero && (k != 0);
        end
    end

    always_comb
    begin
        sel_byte  = q_head.text_byte;
        final_pos = 1'b1;
        if (q_head.numbered)
        begin
            final_pos = (pos_reg == POS_W'(EFF_DIGITS + 1));
            if (pos_reg == POS_W'(EFF_DIGITS))
                sel_byte = CHAR_TAB;
            for (int k = 0; k < EFF_DIGITS; k++)
            begin
                if (pos_reg == POS_W'(EFF_DIGITS - 1 - k))
                begin
                    if (blank_digit[k])
                        sel_byte = CHAR_SPACE;
                    else
                        sel_byte = CHAR_ZERO + {4'd0, q_head.digits[k]};
                end
            end
        end
    end

    assign load  = !q_empty && (!out_valid_reg || result.ready);
    assign q_pop = load && final_pos;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_last_next  = final_pos;
            pos_next       = final_pos ? '0 : pos_reg + 1'b1;
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.last_of_run = out_last_reg;

endmodule

`default_nettype wire

### hdl/text_line_number_squeeze_filter_core.sv
// text_line_number_squeeze_filter_core: top level of the line numbering and squeeze filter
// depends on tlnsf_pkg, tlnsf_if, tlnsf_front, tlnsf_queue and tlnsf_back
//
//  channel  | dir | payload                   | request
//  ---------+-----+---------------------------+------------------------------
//  text     | in  | text_byte, file_start     | one text byte
//  result   | out | out_byte, last_of_run     | one output character
//  cfg_*    | in  | cfg_index, cfg_data       | one register write, no wait
//
//  one text byte is taken per cycle while the queue is not full; a plain byte
//  taken is written into the queue, then loaded into the output stage register
//  and offered on result; a numbered line start leaves as six digits, tab and
//  byte, the back end emitting one byte a cycle unless result stalls
//  the four-entry queue lets the front keep taking bytes while the back expands
//  a stalled result holds the back end only; the front stops when the queue fills
//  reset clears line state to line start, no blank run, counter one, all options off
`default_nettype none

module text_line_number_squeeze_filter_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tlnsf_in_if.sink                                text,
    tlnsf_out_if.source                             result,
    input  wire logic                               cfg_we,
    input  wire logic [tlnsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlnsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tlnsf_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    // option registers; writes to an unused index are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUMBER_ALL:      cfg_next.number_all      = cfg_data[0];
                REG_NUMBER_NONBLANK: cfg_next.number_nonblank = cfg_data[0];
                REG_SQUEEZE:         cfg_next.squeeze         = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // front: classification, blank tracking and the bcd line counter
    tlnsf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .text   (text),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    // decoupling queue of classified commands
    tlnsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back: number formatting and the registered output stage
    tlnsf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire
